### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the seven-segment shift-out checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define L7S_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked implication assertion; the consequent is checked in the cycle after the antecedent.
`define L7S_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/l7s_pkg.sv
// ----------------------------------------------------------------------------
// l7s_pkg
// Types, constants and segment decode for the seven-segment shift-out unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package l7s_pkg;

	localparam int L7S_QUEUE_DEPTH = 2;
	localparam int L7S_PAT_BITS    = 8;

	typedef struct packed {
		logic [7:0] level;
		logic       show;
	} l7s_in_t;

	typedef struct packed {
		logic       line_hundreds;
		logic       line_tens;
		logic       line_units;
		logic [2:0] bit_position;
		logic       latch_now;
	} l7s_out_t;

	typedef struct packed {
		logic [L7S_PAT_BITS-1:0] pat_h;
		logic [L7S_PAT_BITS-1:0] pat_t;
		logic [L7S_PAT_BITS-1:0] pat_u;
	} l7s_pat_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} l7s_qstat_t;

	function automatic logic [L7S_PAT_BITS-1:0] l7s_seg(input logic [3:0] d);
		logic [L7S_PAT_BITS-1:0] p;
		case (d)
			4'd0:    p = 8'b0011_1111;
			4'd1:    p = 8'b0000_0110;
			4'd2:    p = 8'b0101_1011;
			4'd3:    p = 8'b0100_1111;
			4'd4:    p = 8'b0110_0110;
			4'd5:    p = 8'b0110_1101;
			4'd6:    p = 8'b0111_1101;
			4'd7:    p = 8'b0000_0111;
			4'd8:    p = 8'b0111_1111;
			4'd9:    p = 8'b0110_1111;
			default: p = 8'b0000_0000;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### rtl/l7s_front.sv
// ----------------------------------------------------------------------------
// l7s_front
// Accepts a request, splits the level into decimal digits and decodes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module l7s_front (
	input  wire                 item_valid,
	output logic                item_stall,
	input  l7s_pkg::l7s_in_t    item,
	input  l7s_pkg::l7s_qstat_t qstat,
	output logic                push,
	output l7s_pkg::l7s_pat_t   pat
);
	import l7s_pkg::*;

	logic [15:0] prod10;
	logic [13:0] prod100;
	logic [4:0]  q10;
	logic [1:0]  hund;
	logic [4:0]  hund_x10;
	logic [4:0]  tens5;
	logic [7:0]  q10_x10;
	logic [7:0]  units8;

	// divide by constants through reciprocal multiplies, exact for 0..255
	assign prod10   = 16'(item.level) * 16'd205;
	assign prod100  = 14'(item.level) * 14'd41;
	assign q10      = prod10[15:11];
	assign hund     = prod100[13:12];
	assign hund_x10 = {hund, 3'b000} + {2'b00, hund, 1'b0};
	assign tens5    = q10 - hund_x10;
	assign q10_x10  = {q10, 3'b000} + {2'b00, q10, 1'b0};
	assign units8   = item.level - q10_x10;

	always_comb begin
		pat = '0;
		if (item.show) begin
			pat.pat_h = (hund == 2'd0) ? '0 : l7s_seg({2'b00, hund});
			pat.pat_t = l7s_seg(tens5[3:0]);
			pat.pat_u = l7s_seg(units8[3:0]);
		end
	end

	assign item_stall = qstat.full;
	assign push       = item_valid && !qstat.full;

endmodule

`default_nettype wire

### rtl/l7s_queue.sv
// ----------------------------------------------------------------------------
// l7s_queue
// Short queue of decoded patterns between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module l7s_queue #(
	parameter int Depth = l7s_pkg::L7S_QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  l7s_pkg::l7s_pat_t   wr_data,
	input  wire                 pop,
	output l7s_pkg::l7s_pat_t   rd_data,
	output l7s_pkg::l7s_qstat_t qstat
);
	import l7s_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	l7s_pat_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign qstat.full      = (count_q == CntW'(Depth));
	assign qstat.not_empty = (count_q != '0);
	assign rd_data         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/l7s_back.sv
// ----------------------------------------------------------------------------
// l7s_back
// Shifts the head patterns out one bit per result and marks the latch pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module l7s_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  l7s_pkg::l7s_pat_t   head,
	input  l7s_pkg::l7s_qstat_t qstat,
	output logic                pop,
	output logic                result_valid,
	input  wire                 result_stall,
	output l7s_pkg::l7s_out_t   result
);
	import l7s_pkg::*;

	logic [2:0] cnt_q;
	logic       result_valid_q;
	l7s_out_t   result_q;
	logic       adv;

	assign adv          = qstat.not_empty && (!result_valid_q || !result_stall);
	assign pop          = adv && (cnt_q == 3'd7);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.line_hundreds <= head.pat_h[cnt_q];
			result_q.line_tens     <= head.pat_t[cnt_q];
			result_q.line_units    <= head.pat_u[cnt_q];
			result_q.bit_position  <= cnt_q;
			result_q.latch_now     <= (cnt_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				cnt_q          <= cnt_q + 3'd1;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/level_to_seven_segment_shift_out_unit.sv
// ----------------------------------------------------------------------------
// level_to_seven_segment_shift_out_unit
// Three-digit seven-segment serial driver.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: item_valid / item_stall carry a request of a level byte
//   and a show flag. Each request yields eight results on the result
//   channel (result_valid / result_stall): one bit per digit data line,
//   pattern bit 0 first, with latch_now set on the eighth.
//   A taken request enters the pattern queue; the back end registers its
//   first result from the queue head, and the rest follow one per cycle
//   while the receiver takes them. The back end, at one pattern bit per
//   cycle, sets the request rate; the queue holds QueueDepth decoded
//   requests, so a new request is taken while the previous one shifts out.
//   Reset: clears the queue and drops result_valid; no request is pending.
//   Receiver stall: the result holds, the back end waits, the queue fills
//   and item_stall rises once it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module level_to_seven_segment_shift_out_unit #(
	parameter int QueueDepth = l7s_pkg::L7S_QUEUE_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_stall,
	input  l7s_pkg::l7s_in_t  item,
	output logic              result_valid,
	input  wire               result_stall,
	output l7s_pkg::l7s_out_t result
);
	import l7s_pkg::*;

	l7s_qstat_t qstat;
	l7s_pat_t   wr_pat;
	l7s_pat_t   head;
	logic       push;
	logic       pop;

	l7s_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.qstat      (qstat),
		.push       (push),
		.pat        (wr_pat)
	);

	l7s_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_pat),
		.pop     (pop),
		.rd_data (head),
		.qstat   (qstat)
	);

	l7s_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

### rtl/l7s_checker.sv
// ----------------------------------------------------------------------------
// l7s_checker
// Port-level checks for the seven-segment shift-out unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module l7s_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               item_valid,
	input wire               item_stall,
	input l7s_pkg::l7s_in_t  item,
	input wire               result_valid,
	input wire               result_stall,
	input l7s_pkg::l7s_out_t result
);
	import l7s_pkg::*;

	logic       item_wait;
	logic       res_wait;
	logic       res_mid;
	logic       latch_ok;
	logic       bits_off;
	logic       pos_ok;
	logic [2:0] pos_next_q;

	assign item_wait = item_valid && item_stall;
	assign res_wait  = result_valid && result_stall;
	assign res_mid   = result_valid && !result_stall && !result.latch_now;
	assign latch_ok  = !result_valid || (result.latch_now == (result.bit_position == 3'd7));
	assign bits_off  = !(result_valid && result.latch_now) ||
		(!result.line_hundreds && !result.line_tens && !result.line_units);
	assign pos_ok    = result_valid && (result.bit_position == pos_next_q);

	always_ff @(posedge clk) begin
		pos_next_q <= result.bit_position + 3'd1;
	end

	`L7S_ASSERT_NEXT(a_item_hold, clk, arst_n, item_wait, item_valid && $stable(item), "stalled request changed")

	`L7S_ASSERT_NEXT(a_res_hold, clk, arst_n, res_wait, result_valid && $stable(result), "stalled result changed")

	`L7S_ASSERT(a_latch_last, clk, arst_n, latch_ok, "latch mark not on last bit")

	`L7S_ASSERT_NEXT(a_bit_order, clk, arst_n, res_mid, pos_ok, "bit run broken")

	`L7S_ASSERT(a_top_bit_off, clk, arst_n, bits_off, "segment bit 7 driven")

endmodule

bind level_to_seven_segment_shift_out_unit l7s_checker u_l7s_checker (.*);

`default_nettype wire

### tb/level_to_seven_segment_shift_out_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_to_seven_segment_shift_out_unit_tb
// Serial pattern check for the three-digit seven-segment shift-out unit.
// Sends level/show requests, starting with digit and blanking corner cases
// and then random levels. Each request is decoded into the eight serial bit
// slots it should produce. Each result is compared field by field with the
// oldest pending slot. Both sides idle in random bursts, except near the end.
// ----------------------------------------------------------------------------
module level_to_seven_segment_shift_out_unit_tb;

	import l7s_pkg::*;

	localparam int RANDOM_REQUESTS = 450;
	localparam int CALM_TAIL       = 60;
	localparam int CYCLE_LIMIT     = 400000;

	localparam logic [7:0] SEG_GLYPH [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
		8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_stall;
	l7s_in_t  item         = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	l7s_out_t result;

	l7s_in_t  levels_pending[$];
	l7s_out_t bits_due[$];

	int errors      = 0;
	int cycles      = 0;
	int sent_shown  = 0;
	int sent_blank  = 0;
	int bits_seen   = 0;
	int send_gap    = 0;
	int stall_left  = 0;
	bit calm;

	level_to_seven_segment_shift_out_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] glyph(input int digit);
		if (digit > 9)
			return 8'h00;
		return SEG_GLYPH[digit];
	endfunction

	function automatic void shift_out_bits(input l7s_in_t req);
		logic [7:0] pat_h;
		logic [7:0] pat_t;
		logic [7:0] pat_u;
		int       lvl;
		l7s_out_t slot;
		pat_h = 8'h00;
		pat_t = 8'h00;
		pat_u = 8'h00;
		lvl   = int'(req.level);
		if (req.show) begin
			pat_h = (lvl / 100 == 0) ? 8'h00 : glyph(lvl / 100);
			pat_t = glyph((lvl / 10) % 10);
			pat_u = glyph(lvl % 10);
		end
		for (int k = 0; k < 8; k++) begin
			slot.line_hundreds = pat_h[k];
			slot.line_tens     = pat_t[k];
			slot.line_units    = pat_u[k];
			slot.bit_position  = 3'(k);
			slot.latch_now     = (k == 7);
			bits_due.push_back(slot);
		end
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	assign calm = (levels_pending.size() < CALM_TAIL);

	// request driver
	always @(posedge clk) begin : drive_requests
		logic    nv;
		l7s_in_t ni;
		nv = item_valid;
		ni = item;
		if (!arst_n) begin
			nv = 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				shift_out_bits(item);
				if (item.show)
					sent_shown++;
				else
					sent_blank++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (levels_pending.size() > 0) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(0, 12);
					end else begin
						nv = 1'b1;
						ni = levels_pending.pop_front();
					end
				end
			end
		end
		item_valid <= nv;
		item       <= ni;
	end

	// result monitor
	always @(posedge clk) begin : watch_results
		l7s_out_t want;
		logic     ns;
		ns = 1'b0;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				bits_seen++;
				if (bits_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, result);
					errors++;
				end else begin
					want = bits_due.pop_front();
					check_field("line_hundreds", want.line_hundreds, result.line_hundreds);
					check_field("line_tens", want.line_tens, result.line_tens);
					check_field("line_units", want.line_units, result.line_units);
					check_field("bit_position", want.bit_position, result.bit_position);
					check_field("latch_now", want.latch_now, result.latch_now);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				ns = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 12);
				ns = 1'b1;
			end
		end
		result_stall <= ns;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, bits_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_level(input int lvl, input bit show);
		l7s_in_t req;
		req.level = 8'(lvl);
		req.show  = show;
		levels_pending.push_back(req);
	endtask

	initial begin
		// corner cases: extremes, blanked hundreds, zero tens, every digit, show off
		queue_level(0, 1);
		queue_level(0, 0);
		queue_level(255, 1);
		queue_level(255, 0);
		queue_level(5, 1);
		queue_level(9, 1);
		queue_level(10, 1);
		queue_level(99, 1);
		queue_level(100, 1);
		queue_level(105, 1);
		queue_level(123, 1);
		queue_level(200, 1);
		queue_level(146, 1);
		queue_level(178, 1);
		queue_level(239, 1);
		queue_level(250, 1);
		queue_level(67, 1);
		queue_level(170, 0);
		queue_level(85, 0);
		queue_level(1, 1);
		for (int i = 0; i < RANDOM_REQUESTS; i++)
			queue_level($urandom_range(0, 255), $urandom_range(0, 3) != 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain
		do @(posedge clk); while (levels_pending.size() != 0 || item_valid);
		do @(posedge clk); while (bits_due.size() != 0);
		repeat (20) @(posedge clk);

		$display("Sent %0d shown and %0d blank requests, checked %0d serial bits.",
			sent_shown, sent_blank, bits_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
